### sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers; empty when synthesizing.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define VPC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define VPC_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define VPC_ASSERT(label, prop, msg)
`define VPC_ASSERT_RST(label, prop, msg)
`endif

`endif

### sv/vpc_pkg.sv
// ----------------------------------------------------------------------------
// vpc_pkg
// Types, constants and helpers for the voxel projection pipeline.
// ----------------------------------------------------------------------------
package vpc_pkg;

    localparam int COORD_FRAC_BITS = 16;
    localparam int NUM_REGS        = 8;
    localparam int REG_W           = 64;
    localparam int IDX_W           = 4;
    localparam int Q30_BITS        = 30;
    localparam int MAG_W           = 64;
    localparam int SUM_W           = 66;
    localparam logic [7:0] ALPHA_LIMIT = 8'd128;

    localparam logic [IDX_W-1:0] REG_ROW0_COLS01 = 4'd0;
    localparam logic [IDX_W-1:0] REG_ROW3_COLS23 = 4'd7;

    localparam logic [REG_W-1:0] RST_ONE_LO = 64'd65536;
    localparam logic [REG_W-1:0] RST_ONE_HI = 64'd281474976710656;

    typedef logic [MAG_W-1:0] t_mag;
    typedef logic [7:0]       t_chan;

    // one restoring divide step: returns {quotient bit, new remainder}
    function automatic logic [MAG_W:0] div_step(input t_mag rem, input t_mag w);
        logic [MAG_W:0] t;
        logic [MAG_W:0] d;
        t = {rem, 1'b0};
        d = t - {1'b0, w};
        if (t >= {1'b0, w}) begin
            return {1'b1, d[MAG_W-1:0]};
        end
        return {1'b0, t[MAG_W-1:0]};
    endfunction

endpackage

### sv/voxel_project_and_cull.sv
// ----------------------------------------------------------------------------
// voxel_project_and_cull
// Transforms voxels by a 4x4 matrix, divides by w and culls to the frustum.
// ----------------------------------------------------------------------------
// Accepts one voxel per clock while the output is not held, drops voxels
// with alpha at most 128, and passes each survivor through one input
// register stage, one multiply stage (twelve 32x32 multipliers), a row-sum
// stage, a sign/magnitude stage, a cull stage, then a 30-stage restoring
// divider that resolves one quotient bit per stage for x, y and z together.
// When the output is held the whole pipeline freezes. Matrix writes take
// effect on items not yet multiplied; write only while the pipeline is empty.
`include "assert_macros.svh"

module voxel_project_and_cull (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [vpc_pkg::IDX_W-1:0]    i_cfg_index,
    input  logic [vpc_pkg::REG_W-1:0]    i_cfg_data,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic signed [31:0]           i_coord_x,
    input  logic signed [31:0]           i_coord_y,
    input  logic signed [31:0]           i_coord_z,
    input  logic [7:0]                   i_color_red,
    input  logic [7:0]                   i_color_green,
    input  logic [7:0]                   i_color_blue,
    input  logic [7:0]                   i_color_alpha,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic signed [30:0]           o_ndc_x,
    output logic signed [30:0]           o_ndc_y,
    output logic [29:0]                  o_ndc_z,
    output logic [7:0]                   o_out_red,
    output logic [7:0]                   o_out_green,
    output logic [7:0]                   o_out_blue
);
    import vpc_pkg::*;

    localparam int LAST = Q30_BITS - 1;

    logic                  adv;
    logic [REG_W-1:0]      r_cfg [NUM_REGS];

    // stage 1
    logic                  r_v1;
    logic signed [31:0]    r_c1 [3];
    t_chan                 r_r1, r_g1, r_b1;
    // stage 2
    logic                  r_v2;
    logic signed [63:0]    r_p2 [4][4];
    t_chan                 r_r2, r_g2, r_b2;
    // stage 3
    logic                  r_v3;
    logic signed [SUM_W-1:0] r_s3 [4];
    t_chan                 r_r3, r_g3, r_b3;
    // stage 4
    logic                  r_v4;
    t_mag                  r_m4 [4];
    logic [3:0]            r_n4;
    t_chan                 r_r4, r_g4, r_b4;
    // stage 5
    logic                  r_v5;
    t_mag                  r_xm5, r_ym5, r_zm5, r_wm5;
    logic                  r_xs5, r_ys5;
    t_chan                 r_r5, r_g5, r_b5;
    logic                  keep5;
    // divider
    logic                  r_dv [Q30_BITS];
    t_mag                  r_rx [Q30_BITS];
    t_mag                  r_ry [Q30_BITS];
    t_mag                  r_rz [Q30_BITS];
    t_mag                  r_w  [Q30_BITS];
    logic [Q30_BITS-1:0]   r_qx [Q30_BITS];
    logic [Q30_BITS-1:0]   r_qy [Q30_BITS];
    logic [Q30_BITS-1:0]   r_qz [Q30_BITS];
    logic                  r_sx [Q30_BITS];
    logic                  r_sy [Q30_BITS];
    t_chan                 r_rd [Q30_BITS];
    t_chan                 r_gd [Q30_BITS];
    t_chan                 r_bd [Q30_BITS];

    assign adv     = !o_valid || i_ready;
    assign o_ready = adv;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg[0] <= RST_ONE_LO;
            r_cfg[1] <= '0;
            r_cfg[2] <= RST_ONE_HI;
            r_cfg[3] <= '0;
            r_cfg[4] <= '0;
            r_cfg[5] <= RST_ONE_LO;
            r_cfg[6] <= '0;
            r_cfg[7] <= RST_ONE_HI;
        end else if (i_cfg_we && i_cfg_index <= REG_ROW3_COLS23) begin
            r_cfg[i_cfg_index[2:0]] <= i_cfg_data;
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            for (int k = 0; k < Q30_BITS; k++) begin
                r_dv[k] <= 1'b0;
            end
        end else if (adv) begin
            r_v1 <= i_valid && (i_color_alpha > ALPHA_LIMIT);
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4 && keep5;
            r_dv[0] <= r_v5;
            for (int k = 1; k < Q30_BITS; k++) begin
                r_dv[k] <= r_dv[k-1];
            end
        end
    end

    // stage 1: input capture
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_c1[0] <= i_coord_x;
            r_c1[1] <= i_coord_y;
            r_c1[2] <= i_coord_z;
            r_r1    <= i_color_red;
            r_g1    <= i_color_green;
            r_b1    <= i_color_blue;
        end
    end

    // stage 2: products
    for (genvar gr = 0; gr < 4; gr++) begin : g_row
        for (genvar gc = 0; gc < 4; gc++) begin : g_col
            logic signed [31:0] elem;
            logic signed [63:0] prod;
            assign elem = signed'(r_cfg[gr*2 + gc/2][(gc%2)*32 +: 32]);
            if (gc < 3) begin : g_mul
                assign prod = elem * r_c1[gc];
            end else begin : g_one
                assign prod = 64'(elem) <<< COORD_FRAC_BITS;
            end
            always_ff @(posedge i_clk) begin
                if (adv) begin
                    r_p2[gr][gc] <= prod;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_r2 <= r_r1;
            r_g2 <= r_g1;
            r_b2 <= r_b1;
            for (int i = 0; i < 4; i++) begin
                r_s3[i] <= SUM_W'(r_p2[i][0]) + SUM_W'(r_p2[i][1])
                         + SUM_W'(r_p2[i][2]) + SUM_W'(r_p2[i][3]);
            end
            r_r3 <= r_r2;
            r_g3 <= r_g2;
            r_b3 <= r_b2;
            for (int i = 0; i < 4; i++) begin
                r_n4[i] <= r_s3[i][SUM_W-1];
                r_m4[i] <= r_s3[i][SUM_W-1] ? MAG_W'(-r_s3[i]) : MAG_W'(r_s3[i]);
            end
            r_r4 <= r_r3;
            r_g4 <= r_g3;
            r_b4 <= r_b3;
            r_xm5 <= r_m4[0];
            r_ym5 <= r_m4[1];
            r_zm5 <= r_m4[2];
            r_wm5 <= r_m4[3];
            r_xs5 <= r_n4[0] ^ r_n4[3];
            r_ys5 <= r_n4[1] ^ r_n4[3];
            r_r5  <= r_r4;
            r_g5  <= r_g4;
            r_b5  <= r_b4;
        end
    end

    // cull test on exact magnitudes
    assign keep5 = (r_m4[3] != '0) && (r_m4[0] < r_m4[3]) && (r_m4[1] < r_m4[3])
                && (r_m4[2] != '0) && (r_m4[2] < r_m4[3]) && (r_n4[2] == r_n4[3]);

    // divider pipeline, one quotient bit per stage
    for (genvar k = 0; k < Q30_BITS; k++) begin : g_div
        t_mag                pw, px, py, pz;
        logic [Q30_BITS-1:0] qx, qy, qz;
        logic [MAG_W:0]      sx, sy, sz;
        logic                psx, psy;
        t_chan               pr, pg, pb;
        if (k == 0) begin : g_first
            assign pw  = r_wm5;
            assign px  = r_xm5;
            assign py  = r_ym5;
            assign pz  = r_zm5;
            assign qx  = '0;
            assign qy  = '0;
            assign qz  = '0;
            assign psx = r_xs5;
            assign psy = r_ys5;
            assign pr  = r_r5;
            assign pg  = r_g5;
            assign pb  = r_b5;
        end else begin : g_next
            assign pw  = r_w[k-1];
            assign px  = r_rx[k-1];
            assign py  = r_ry[k-1];
            assign pz  = r_rz[k-1];
            assign qx  = r_qx[k-1];
            assign qy  = r_qy[k-1];
            assign qz  = r_qz[k-1];
            assign psx = r_sx[k-1];
            assign psy = r_sy[k-1];
            assign pr  = r_rd[k-1];
            assign pg  = r_gd[k-1];
            assign pb  = r_bd[k-1];
        end
        assign sx = div_step(px, pw);
        assign sy = div_step(py, pw);
        assign sz = div_step(pz, pw);
        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_w[k]  <= pw;
                r_rx[k] <= sx[MAG_W-1:0];
                r_ry[k] <= sy[MAG_W-1:0];
                r_rz[k] <= sz[MAG_W-1:0];
                r_qx[k] <= {qx[Q30_BITS-2:0], sx[MAG_W]};
                r_qy[k] <= {qy[Q30_BITS-2:0], sy[MAG_W]};
                r_qz[k] <= {qz[Q30_BITS-2:0], sz[MAG_W]};
                r_sx[k] <= psx;
                r_sy[k] <= psy;
                r_rd[k] <= pr;
                r_gd[k] <= pg;
                r_bd[k] <= pb;
            end
        end
    end

    assign o_valid     = r_dv[LAST];
    assign o_ndc_x     = r_sx[LAST] ? -$signed({1'b0, r_qx[LAST]}) : $signed({1'b0, r_qx[LAST]});
    assign o_ndc_y     = r_sy[LAST] ? -$signed({1'b0, r_qy[LAST]}) : $signed({1'b0, r_qy[LAST]});
    assign o_ndc_z     = r_qz[LAST];
    assign o_out_red   = r_rd[LAST];
    assign o_out_green = r_gd[LAST];
    assign o_out_blue  = r_bd[LAST];

    `VPC_ASSERT(a_rem_x_below_w, o_valid |-> r_rx[LAST] < r_w[LAST], "x remainder not below w")
    `VPC_ASSERT(a_rem_y_below_w, o_valid |-> r_ry[LAST] < r_w[LAST], "y remainder not below w")
    `VPC_ASSERT(a_rem_z_below_w, o_valid |-> r_rz[LAST] < r_w[LAST], "z remainder not below w")
    `VPC_ASSERT(a_cull_w_nonzero, r_v5 |-> (r_wm5 != '0 && r_zm5 < r_wm5), "bad w after cull")
    `VPC_ASSERT(a_stall_freeze, !adv |=> $stable({r_v1, r_v5, r_dv[0]}), "moved while stalled")
    `VPC_ASSERT_RST(a_reset_empty, !i_rst_n |=> !o_valid, "output valid after reset")

endmodule
